/* rtl/core/bbc_pkg.sv */
// Shared types and constants of the LRU block buffer cache.
package bbc_pkg;

  // Command kinds carried in the input word.
  typedef enum logic [2:0] {
    KIND_GET      = 3'd0,
    KIND_RELEASE  = 3'd1,
    KIND_INVAL    = 3'd2,
    KIND_DISABLE  = 3'd3,
    KIND_ENABLE   = 3'd4,
    KIND_SETFLAGS = 3'd5
  } kind_t;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_BUFFER = 2'd1;
  localparam logic [1:0] STATUS_NOT_HELD  = 2'd2;

  // Update broadcast from the controller to every cell.
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_CLAIM,
    UPD_RELEASE,
    UPD_INVAL,
    UPD_DISABLE,
    UPD_SETFLAGS
  } upd_op_t;

  // Recency move that goes with a release.
  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_HEAD,
    MOVE_TAIL
  } move_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 16;
  localparam logic [7:0]  REFS_MAX   = 8'hFF;

endpackage

/* rtl/core/bbc_cell.sv */
// One buffer entry of the cache with its stage of the search chain.
module bbc_cell
  import bbc_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned INDEX       = 0,
  parameter int unsigned IW          = 5
) (
  input  logic          clk,
  input  logic          rst,
  // Command fields held by the controller.
  input  logic [7:0]    cmd_device,
  input  logic [31:0]   cmd_block,
  input  logic          cmd_nc,
  input  logic          cmd_vin,
  input  logic          cmd_din,
  input  logic [IW-1:0] sel_idx,
  // Update broadcast.
  input  upd_op_t       upd_op,
  input  logic [IW-1:0] upd_idx,
  input  move_t         upd_move,
  input  logic [IW-1:0] upd_rank,
  input  logic          upd_clrv,
  // Search token from the previous cell.
  input  logic          in_go,
  input  logic          in_hit_f,
  input  logic [IW-1:0] in_hit_rank,
  input  logic [IW-1:0] in_hit_idx,
  input  logic          in_hit_v,
  input  logic          in_hit_d,
  input  logic          in_free_f,
  input  logic [IW-1:0] in_free_rank,
  input  logic [IW-1:0] in_free_idx,
  input  logic [7:0]    in_tgt_refs,
  input  logic [IW-1:0] in_tgt_rank,
  input  logic          in_tgt_v,
  input  logic          in_tgt_d,
  input  logic          in_tgt_unc,
  // Search token to the next cell.
  output logic          out_go,
  output logic          out_hit_f,
  output logic [IW-1:0] out_hit_rank,
  output logic [IW-1:0] out_hit_idx,
  output logic          out_hit_v,
  output logic          out_hit_d,
  output logic          out_free_f,
  output logic [IW-1:0] out_free_rank,
  output logic [IW-1:0] out_free_idx,
  output logic [7:0]    out_tgt_refs,
  output logic [IW-1:0] out_tgt_rank,
  output logic          out_tgt_v,
  output logic          out_tgt_d,
  output logic          out_tgt_unc
);

  localparam logic [IW-1:0] MY_IDX    = IW'(INDEX);
  localparam logic [IW-1:0] RESET_RNK = IW'(NUM_BUFFERS - 1 - INDEX);
  localparam logic [IW-1:0] TAIL_RNK  = IW'(NUM_BUFFERS - 1);

  logic [7:0]    device;
  logic [31:0]   block;
  logic          valid;
  logic          dirty;
  logic          uncached;
  logic [7:0]    refs;
  logic [IW-1:0] rank;

  logic tag_match;
  logic is_free;
  logic take_hit;
  logic take_free;
  logic is_upd;

  assign tag_match = (device == cmd_device) && (block == cmd_block);
  assign is_free   = (refs == 8'd0) && !dirty;
  assign take_hit  = tag_match && (!in_hit_f || (rank < in_hit_rank));
  assign take_free = is_free && (!in_free_f || (rank > in_free_rank));
  assign is_upd    = (upd_idx == MY_IDX);

  // Search stage: fold this entry into the token and pass it on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_go <= 1'b0;
    end else begin
      out_go <= in_go;
    end
    out_hit_f     <= in_hit_f || take_hit;
    out_hit_rank  <= take_hit ? rank : in_hit_rank;
    out_hit_idx   <= take_hit ? MY_IDX : in_hit_idx;
    out_hit_v     <= take_hit ? valid : in_hit_v;
    out_hit_d     <= take_hit ? dirty : in_hit_d;
    out_free_f    <= in_free_f || take_free;
    out_free_rank <= take_free ? rank : in_free_rank;
    out_free_idx  <= take_free ? MY_IDX : in_free_idx;
    if (sel_idx == MY_IDX) begin
      out_tgt_refs <= refs;
      out_tgt_rank <= rank;
      out_tgt_v    <= valid;
      out_tgt_d    <= dirty;
      out_tgt_unc  <= uncached;
    end else begin
      out_tgt_refs <= in_tgt_refs;
      out_tgt_rank <= in_tgt_rank;
      out_tgt_v    <= in_tgt_v;
      out_tgt_d    <= in_tgt_d;
      out_tgt_unc  <= in_tgt_unc;
    end
  end

  // Entry state: apply the broadcast update.
  always_ff @(posedge clk) begin
    if (rst) begin
      device   <= 8'd0;
      block    <= 32'd0;
      valid    <= 1'b0;
      dirty    <= 1'b0;
      uncached <= 1'b0;
      refs     <= 8'd0;
      rank     <= RESET_RNK;
    end else begin
      unique case (upd_op)
        UPD_HIT: begin
          if (is_upd && refs != REFS_MAX) begin
            refs <= refs + 8'd1;
          end
        end
        UPD_CLAIM: begin
          if (is_upd) begin
            device   <= cmd_device;
            block    <= cmd_block;
            valid    <= 1'b0;
            dirty    <= 1'b0;
            uncached <= cmd_nc;
            refs     <= 8'd1;
          end
        end
        UPD_RELEASE: begin
          if (is_upd) begin
            refs <= refs - 8'd1;
            if (upd_clrv) begin
              valid <= 1'b0;
            end
            if (upd_move == MOVE_HEAD) begin
              rank <= '0;
            end else if (upd_move == MOVE_TAIL) begin
              rank <= TAIL_RNK;
            end
          end else if (upd_move == MOVE_HEAD && rank < upd_rank) begin
            rank <= rank + IW'(1);
          end else if (upd_move == MOVE_TAIL && rank > upd_rank) begin
            rank <= rank - IW'(1);
          end
        end
        UPD_INVAL: begin
          if (device == cmd_device) begin
            valid <= 1'b0;
            dirty <= 1'b0;
          end
        end
        UPD_DISABLE: begin
          if (is_free) begin
            valid <= 1'b0;
          end
        end
        UPD_SETFLAGS: begin
          if (is_upd) begin
            valid <= cmd_vin;
            dirty <= cmd_din;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/block_buffer_cache_lru.sv */
// Top level of the LRU block buffer cache: controller and chain of entry cells.
//
// Commands arrive as words on the s_axis channel and each one gives exactly
// one result word on the m_axis channel. Get looks up a device and block,
// release drops a reference and, when the last one goes, reorders recency,
// and the other kinds invalidate a device, switch caching off or on, or set
// an entry's flags. A command is taken only while the controller is idle.
// It launches a search token that walks the chain of entry cells, one cell
// per cycle, collecting the most recent tag hit, the least recent free entry
// and the addressed entry. When the token leaves the last cell, the update
// state broadcasts the update to all cells and loads the result register.
// Each command passes the token launch register, every cell of the chain,
// the scan state and the update state in turn, and no new command is taken
// until the current one has loaded its result. The next command is accepted
// in the cycle after the result is loaded; if the receiver stalls, the
// result waits in its register and the following command holds in its
// update cycle until that word leaves.
// Reset clears every entry, makes the highest entry most recent, enables
// caching and drops any pending result.
module block_buffer_cache_lru
  import bbc_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // kind[2:0], device[10:3], block_id[42:11], no_cache[43],
  // buffer_index[48:44], valid_in[49], dirty_in[50], zero fill above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[1:0], entry_out[6:2], was_hit[7], valid_out[8], dirty_out[9],
  // caching_on[10], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned N  = NUM_BUFFERS;

  state_t state, state_next;

  // Held command word.
  logic [2:0]    cmd_kind;
  logic [7:0]    cmd_device;
  logic [31:0]   cmd_block;
  logic          cmd_nc;
  logic [4:0]    cmd_idx;
  logic          cmd_vin;
  logic          cmd_din;
  logic          cmd_inrange;
  logic [IW-1:0] sel_idx;
  logic          cache_en;
  logic          go;

  // Search chain.
  logic          c_go        [N+1];
  logic          c_hit_f     [N+1];
  logic [IW-1:0] c_hit_rank  [N+1];
  logic [IW-1:0] c_hit_idx   [N+1];
  logic          c_hit_v     [N+1];
  logic          c_hit_d     [N+1];
  logic          c_free_f    [N+1];
  logic [IW-1:0] c_free_rank [N+1];
  logic [IW-1:0] c_free_idx  [N+1];
  logic [7:0]    c_tgt_refs  [N+1];
  logic [IW-1:0] c_tgt_rank  [N+1];
  logic          c_tgt_v     [N+1];
  logic          c_tgt_d     [N+1];
  logic          c_tgt_unc   [N+1];

  // Update broadcast and result.
  upd_op_t       upd_op;
  logic [IW-1:0] upd_idx;
  move_t         upd_move;
  logic [IW-1:0] upd_rank;
  logic          upd_clrv;
  logic          apply;
  logic          cache_en_next;
  logic [1:0]    r_status;
  logic [4:0]    r_entry;
  logic          r_hit;
  logic          r_valid;
  logic          r_dirty;
  logic          out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic          accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cmd_inrange   = ({27'd0, cmd_idx} < 32'(N));
  assign sel_idx       = IW'(cmd_idx);

  // Command capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind   <= s_axis_tdata[2:0];
      cmd_device <= s_axis_tdata[10:3];
      cmd_block  <= s_axis_tdata[42:11];
      cmd_nc     <= s_axis_tdata[43];
      cmd_idx    <= s_axis_tdata[48:44];
      cmd_vin    <= s_axis_tdata[49];
      cmd_din    <= s_axis_tdata[50];
    end
  end

  // Seed of the search token.
  assign c_go[0]        = go;
  assign c_hit_f[0]     = 1'b0;
  assign c_hit_rank[0]  = '0;
  assign c_hit_idx[0]   = '0;
  assign c_hit_v[0]     = 1'b0;
  assign c_hit_d[0]     = 1'b0;
  assign c_free_f[0]    = 1'b0;
  assign c_free_rank[0] = '0;
  assign c_free_idx[0]  = '0;
  assign c_tgt_refs[0]  = 8'd0;
  assign c_tgt_rank[0]  = '0;
  assign c_tgt_v[0]     = 1'b0;
  assign c_tgt_d[0]     = 1'b0;
  assign c_tgt_unc[0]   = 1'b0;

  // Chain of entry cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    bbc_cell #(
      .NUM_BUFFERS(NUM_BUFFERS),
      .INDEX      (i),
      .IW         (IW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd_device   (cmd_device),
      .cmd_block    (cmd_block),
      .cmd_nc       (cmd_nc),
      .cmd_vin      (cmd_vin),
      .cmd_din      (cmd_din),
      .sel_idx      (sel_idx),
      .upd_op       (upd_op),
      .upd_idx      (upd_idx),
      .upd_move     (upd_move),
      .upd_rank     (upd_rank),
      .upd_clrv     (upd_clrv),
      .in_go        (c_go[i]),
      .in_hit_f     (c_hit_f[i]),
      .in_hit_rank  (c_hit_rank[i]),
      .in_hit_idx   (c_hit_idx[i]),
      .in_hit_v     (c_hit_v[i]),
      .in_hit_d     (c_hit_d[i]),
      .in_free_f    (c_free_f[i]),
      .in_free_rank (c_free_rank[i]),
      .in_free_idx  (c_free_idx[i]),
      .in_tgt_refs  (c_tgt_refs[i]),
      .in_tgt_rank  (c_tgt_rank[i]),
      .in_tgt_v     (c_tgt_v[i]),
      .in_tgt_d     (c_tgt_d[i]),
      .in_tgt_unc   (c_tgt_unc[i]),
      .out_go       (c_go[i+1]),
      .out_hit_f    (c_hit_f[i+1]),
      .out_hit_rank (c_hit_rank[i+1]),
      .out_hit_idx  (c_hit_idx[i+1]),
      .out_hit_v    (c_hit_v[i+1]),
      .out_hit_d    (c_hit_d[i+1]),
      .out_free_f   (c_free_f[i+1]),
      .out_free_rank(c_free_rank[i+1]),
      .out_free_idx (c_free_idx[i+1]),
      .out_tgt_refs (c_tgt_refs[i+1]),
      .out_tgt_rank (c_tgt_rank[i+1]),
      .out_tgt_v    (c_tgt_v[i+1]),
      .out_tgt_d    (c_tgt_d[i+1]),
      .out_tgt_unc  (c_tgt_unc[i+1])
    );
  end

  // State register, token launch, caching flag and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      go        <= 1'b0;
      cache_en  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      go    <= accept;
      if (apply) begin
        cache_en  <= cache_en_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (apply) begin
      out_data <= {5'd0, cache_en_next, r_dirty, r_valid, r_hit, r_entry, r_status};
    end
  end

  // Next state, update decode and result fields.
  always_comb begin
    state_next    = state;
    apply         = 1'b0;
    upd_op        = UPD_NONE;
    upd_idx       = sel_idx;
    upd_move      = MOVE_NONE;
    upd_rank      = c_tgt_rank[N];
    upd_clrv      = 1'b0;
    cache_en_next = cache_en;
    r_status      = STATUS_OK;
    r_entry       = 5'd0;
    r_hit         = 1'b0;
    r_valid       = 1'b0;
    r_dirty       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (c_go[N]) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!out_valid || m_axis_tready) begin
          apply      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    case (cmd_kind)
      KIND_GET: begin
        if (c_hit_f[N]) begin
          upd_op  = UPD_HIT;
          upd_idx = c_hit_idx[N];
          r_entry = 5'(c_hit_idx[N]);
          r_hit   = 1'b1;
          r_valid = c_hit_v[N];
          r_dirty = c_hit_d[N];
        end else if (c_free_f[N]) begin
          upd_op  = UPD_CLAIM;
          upd_idx = c_free_idx[N];
          r_entry = 5'(c_free_idx[N]);
        end else begin
          r_status = STATUS_NO_BUFFER;
        end
      end
      KIND_RELEASE: begin
        r_entry = cmd_idx;
        if (!cmd_inrange) begin
          r_status = STATUS_NOT_HELD;
        end else if (c_tgt_refs[N] == 8'd0) begin
          r_status = STATUS_NOT_HELD;
          r_valid  = c_tgt_v[N];
          r_dirty  = c_tgt_d[N];
        end else begin
          upd_op = UPD_RELEASE;
          if (c_tgt_refs[N] == 8'd1) begin
            upd_move = (!cache_en || c_tgt_unc[N]) ? MOVE_TAIL : MOVE_HEAD;
            upd_clrv = !cache_en && !c_tgt_d[N];
          end
          r_valid = upd_clrv ? 1'b0 : c_tgt_v[N];
          r_dirty = c_tgt_d[N];
        end
      end
      KIND_INVAL: begin
        upd_op = UPD_INVAL;
      end
      KIND_DISABLE: begin
        if (cache_en) begin
          upd_op = UPD_DISABLE;
        end
        cache_en_next = 1'b0;
      end
      KIND_ENABLE: begin
        cache_en_next = 1'b1;
      end
      KIND_SETFLAGS: begin
        if (cmd_inrange) begin
          upd_op  = UPD_SETFLAGS;
          r_entry = cmd_idx;
          r_valid = cmd_vin;
          r_dirty = cmd_din;
        end
      end
      default: begin
      end
    endcase

    if (!apply) begin
      upd_op = UPD_NONE;
    end
  end

endmodule

/* verif/bbc_checker.sv */
// Checker for the LRU block buffer cache: predicts each result word and compares it.
module bbc_checker
  import bbc_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count,
  output int                    pending_count,
  output int                    hit_count,
  output int                    miss_fail_count
);

  // Result fields, listed from the most significant bit down.
  typedef struct packed {
    logic       caching;
    logic       dirty;
    logic       valid;
    logic       hit;
    logic [4:0] entry;
    logic [1:0] status;
  } outcome_t;

  logic [7:0]  tag_dev   [NUM_BUFFERS];
  logic [31:0] tag_blk   [NUM_BUFFERS];
  logic        ent_valid [NUM_BUFFERS];
  logic        ent_dirty [NUM_BUFFERS];
  logic        ent_nc    [NUM_BUFFERS];
  logic [7:0]  ent_refs  [NUM_BUFFERS];
  int          ent_rank  [NUM_BUFFERS];
  logic        caching;
  outcome_t    expected_results[$];

  // Recency reorder when a count falls to zero.
  function automatic void to_head(int e);
    for (int i = 0; i < NUM_BUFFERS; i++)
      if (ent_rank[i] < ent_rank[e]) ent_rank[i]++;
    ent_rank[e] = 0;
  endfunction

  function automatic void to_tail(int e);
    for (int i = 0; i < NUM_BUFFERS; i++)
      if (ent_rank[i] > ent_rank[e]) ent_rank[i]--;
    ent_rank[e] = NUM_BUFFERS - 1;
  endfunction

  // Apply one command to the shadow cache and return its result.
  function automatic outcome_t cache_command(logic [IN_DATA_W-1:0] w);
    logic [2:0]  kind;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  idx;
    int          best;
    logic        have;
    outcome_t    o;
    kind = w[2:0];
    dev  = w[10:3];
    blk  = w[42:11];
    idx  = w[48:44];
    o    = '0;
    have = 1'b0;
    best = -1;
    case (kind)
      KIND_GET: begin
        for (int i = 0; i < NUM_BUFFERS; i++)
          if (tag_dev[i] == dev && tag_blk[i] == blk &&
              (best < 0 || ent_rank[i] < ent_rank[best])) best = i;
        if (best >= 0) begin
          if (ent_refs[best] != REFS_MAX) ent_refs[best]++;
          o.entry = best[4:0];
          o.hit = 1'b1;
          have = 1'b1;
        end else begin
          for (int i = 0; i < NUM_BUFFERS; i++)
            if (ent_refs[i] == 0 && !ent_dirty[i] &&
                (best < 0 || ent_rank[i] > ent_rank[best])) best = i;
          if (best >= 0) begin
            tag_dev[best] = dev;
            tag_blk[best] = blk;
            ent_valid[best] = 1'b0;
            ent_dirty[best] = 1'b0;
            ent_nc[best] = w[43];
            ent_refs[best] = 8'd1;
            o.entry = best[4:0];
            have = 1'b1;
          end else begin
            o.status = STATUS_NO_BUFFER;
          end
        end
      end
      KIND_RELEASE: begin
        o.entry = idx;
        if (idx >= NUM_BUFFERS) begin
          o.status = STATUS_NOT_HELD;
        end else begin
          have = 1'b1;
          if (ent_refs[idx] == 0) begin
            o.status = STATUS_NOT_HELD;
          end else begin
            ent_refs[idx]--;
            if (ent_refs[idx] == 0) begin
              if (!caching) begin
                if (!ent_dirty[idx]) ent_valid[idx] = 1'b0;
                to_tail(idx);
              end else if (ent_nc[idx]) begin
                to_tail(idx);
              end else begin
                to_head(idx);
              end
            end
          end
        end
      end
      KIND_INVAL: begin
        for (int i = 0; i < NUM_BUFFERS; i++)
          if (tag_dev[i] == dev) begin
            ent_valid[i] = 1'b0;
            ent_dirty[i] = 1'b0;
          end
      end
      KIND_DISABLE: begin
        if (caching) begin
          for (int i = 0; i < NUM_BUFFERS; i++)
            if (ent_refs[i] == 0 && !ent_dirty[i]) ent_valid[i] = 1'b0;
          caching = 1'b0;
        end
      end
      KIND_ENABLE: caching = 1'b1;
      KIND_SETFLAGS: begin
        if (idx < NUM_BUFFERS) begin
          ent_valid[idx] = w[49];
          ent_dirty[idx] = w[50];
          o.entry = idx;
          have = 1'b1;
        end
      end
      default: ;
    endcase
    if (have && o.entry < NUM_BUFFERS) begin
      o.valid = ent_valid[o.entry];
      o.dirty = ent_dirty[o.entry];
    end
    o.caching = caching;
    return o;
  endfunction

  // Track commands and results at each rising edge.
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        ent_valid[i] = 1'b0;
        ent_dirty[i] = 1'b0;
        ent_nc[i] = 1'b0;
        ent_refs[i] = '0;
        ent_rank[i] = NUM_BUFFERS - 1 - i;
      end
      caching = 1'b1;
      expected_results.delete();
      fail_count = 0;
      hit_count = 0;
      miss_fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[10:0];
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.entry !== want.entry) begin
            $error("entry_out: expected %0d, got %0d", want.entry, got.entry);
            fail_count++;
          end
          if (got.hit !== want.hit) begin
            $error("was_hit: expected %0d, got %0d", want.hit, got.hit);
            fail_count++;
          end
          if (got.valid !== want.valid) begin
            $error("valid_out: expected %0d, got %0d", want.valid, got.valid);
            fail_count++;
          end
          if (got.dirty !== want.dirty) begin
            $error("dirty_out: expected %0d, got %0d", want.dirty, got.dirty);
            fail_count++;
          end
          if (got.caching !== want.caching) begin
            $error("caching_on: expected %0d, got %0d", want.caching, got.caching);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = cache_command(s_axis_tdata);
        if (want.hit) hit_count++;
        if (want.status == STATUS_NO_BUFFER) miss_fail_count++;
        expected_results.push_back(want);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

/* verif/tb_block_buffer_cache_lru.sv */
// Testbench top for the LRU block buffer cache: stimulus, back-pressure and verdict.
module tb_block_buffer_cache_lru;
  import bbc_pkg::*;

  localparam int unsigned NBUF       = 32;
  localparam int unsigned LATENCY    = NBUF + 3;
  localparam int          IDLE_LIMIT = 2000;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    fail_count;
  int                    pending_count;
  int                    hit_count;
  int                    miss_fail_count;
  int                    words_sent;
  int                    idle_cycles;
  bit                    quiet_tail;
  bit                    hold_sink;
  logic [31:0]           hot_blk[4];

  block_buffer_cache_lru #(.NUM_BUFFERS(NBUF)) dut (.*);

  bbc_checker #(.NUM_BUFFERS(NBUF)) u_checker (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Build one command word with the fields packed from bit 0 upward.
  function automatic logic [IN_DATA_W-1:0] pack_cmd(kind_t kind, logic [7:0] dev,
      logic [31:0] blk, logic nc, logic [4:0] idx, logic vin, logic din);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[2:0]   = kind;
    w[10:3]  = dev;
    w[42:11] = blk;
    w[43]    = nc;
    w[48:44] = idx;
    w[49]    = vin;
    w[50]    = din;
    return w;
  endfunction

  // Offer one word and hold it until taken; random gaps before it.
  task automatic send_word(logic [IN_DATA_W-1:0] w);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_cmd(kind_t kind, logic [7:0] dev, logic [31:0] blk, logic nc,
      logic [4:0] idx, logic vin, logic din);
    send_word(pack_cmd(kind, dev, blk, nc, idx, vin, din));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Mostly well-formed get/release traffic over a small working set.
  task automatic random_cmd();
    int pick;
    logic [4:0] idx;
    pick = $urandom_range(0, 99);
    idx = $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7) + 24);
    if (pick < 45)
      send_cmd(KIND_GET, 8'($urandom_range(0, 3)),
               $urandom_range(0, 1) ? hot_blk[$urandom_range(0, 3)] : $urandom,
               1'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
    else if (pick < 80)
      send_cmd(KIND_RELEASE, 8'($urandom), $urandom, 1'($urandom), idx,
               1'($urandom), 1'($urandom));
    else if (pick < 85)
      send_cmd(KIND_INVAL, 8'($urandom_range(0, 3)), $urandom, 1'($urandom),
               5'($urandom), 1'($urandom), 1'($urandom));
    else if (pick < 88)
      send_cmd(KIND_DISABLE, 8'($urandom), $urandom, 1'($urandom), 5'($urandom),
               1'($urandom), 1'($urandom));
    else if (pick < 92)
      send_cmd(KIND_ENABLE, 8'($urandom), $urandom, 1'($urandom), 5'($urandom),
               1'($urandom), 1'($urandom));
    else if (pick < 98)
      send_cmd(KIND_SETFLAGS, 8'($urandom), $urandom, 1'($urandom), idx,
               1'($urandom), $urandom_range(0, 3) == 0);
    else
      send_word(pack_cmd(kind_t'(3'd6 + 3'($urandom_range(0, 1))), 8'($urandom),
                $urandom, 1'($urandom), 5'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // Receiver: random stall bursts, a long hold when requested, none at the end.
  always @(negedge clk) begin
    if (rst || quiet_tail) begin
      m_axis_tready <= 1'b1;
    end else if (hold_sink) begin
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_block_buffer_cache_lru: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    quiet_tail = 1'b0;
    hold_sink = 1'b0;
    words_sent = 0;
    idle_cycles = 0;
    for (int i = 0; i < 4; i++) hot_blk[i] = $urandom;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: never-claimed entries hit on device 0, block 0.
    send_cmd(KIND_GET, 8'd0, 32'd0, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_GET, 8'hFF, 32'hFFFF_FFFF, 1'b1, 5'd31, 1'b1, 1'b1);
    send_cmd(KIND_GET, 8'hFF, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_SETFLAGS, 8'd0, 32'd0, 1'b0, 5'd0, 1'b1, 1'b1);
    send_cmd(KIND_RELEASE, 8'd0, 32'd0, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_RELEASE, 8'd0, 32'd0, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_RELEASE, 8'd0, 32'd0, 1'b0, 5'd31, 1'b0, 1'b0);
    send_cmd(KIND_RELEASE, 8'd0, 32'd0, 1'b0, 5'd31, 1'b0, 1'b0);
    send_cmd(KIND_INVAL, 8'hFF, 32'd0, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_DISABLE, 8'd0, 32'd0, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_DISABLE, 8'd0, 32'd0, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_GET, 8'd7, 32'h1234_5678, 1'b0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_SETFLAGS, 8'd0, 32'd0, 1'b0, 5'd30, 1'b1, 1'b0);
    send_cmd(KIND_RELEASE, 8'd0, 32'd0, 1'b0, 5'd30, 1'b0, 1'b0);
    send_cmd(KIND_ENABLE, 8'd0, 32'd0, 1'b0, 5'd0, 1'b0, 1'b0);
    send_word(pack_cmd(kind_t'(3'd6), 8'd1, 32'd1, 1'b1, 5'd1, 1'b1, 1'b1));
    send_word(pack_cmd(kind_t'(3'd7), 8'd1, 32'd1, 1'b1, 5'd1, 1'b1, 1'b1));
    // Count saturation on one entry, then exhaust the free pool.
    repeat (258) send_cmd(KIND_GET, 8'd9, 32'hA5A5_0001, 1'b0, 5'd0, 1'b0, 1'b0);
    for (int i = 0; i < NBUF + 1; i++)
      send_cmd(KIND_GET, 8'd2, 32'(i + 100), 1'b0, 5'd0, 1'b0, 1'b0);
    drain_results();
    // Release each entry once so most of the pool is free again.
    for (int i = 0; i < NBUF; i++)
      send_cmd(KIND_RELEASE, 8'd0, 32'd0, 1'b0, 5'(i), 1'b0, 1'b0);

    // Receiver holds off while the sender keeps offering words.
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(negedge clk);
        hold_sink = 1'b0;
      end
      repeat (10) random_cmd();
    join
    drain_results();

    for (int n = 0; n < 50; n++) begin
      if (n == 40) quiet_tail = 1'b1;
      random_cmd();
      if (n == 25) drain_results();
    end
    drain_results();
    repeat (LATENCY + 5) @(negedge clk);

    $display("Sent %0d command words; %0d gets hit and %0d found no free buffer.",
             words_sent, hit_count, miss_fail_count);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_block_buffer_cache_lru: clean");
    else
      $display("tb_block_buffer_cache_lru: errors");
    $finish;
  end

endmodule

/* block_buffer_cache_lru.f */
rtl/core/bbc_pkg.sv
rtl/core/bbc_cell.sv
rtl/core/block_buffer_cache_lru.sv
verif/bbc_checker.sv
verif/tb_block_buffer_cache_lru.sv
